// ===== src/gbfs_pkg.sv =====
// gbfs_pkg: operation and status codes for the graph breadth-first search block.
// No dependencies; used by graph_breadth_first_search.
package gbfs_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STS_VISIT = 2'd0,
    STS_OK    = 2'd1,
    STS_FULL  = 2'd2,
    STS_RANGE = 2'd3
  } status_t;

  // Register byte addresses
  localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;

  localparam logic [6:0] VERTEX_COUNT_RST = 7'd64;

endpackage

// ===== src/graph_breadth_first_search.sv =====
// graph_breadth_first_search: adjacency-list graph store with breadth-first walk.
// Depends on gbfs_pkg (operation and status codes).
//
// User notes: an item is taken on a clock edge with start high and busy low.
// Every item except operation 3 gives results, each shown for exactly one
// cycle with out_valid high; the receiver must take it then, the block never
// waits. An add edge that is stored does two read-modify-write appends on
// the list memory; a rejected add, a clear and a search with an out-of-range
// source give their one result in the cycle after the item is taken. A
// valid search visits each vertex in ST_POP and ST_VTX, reads the list head
// in ST_HEAD for a vertex with a nonempty list, walks its neighbor slots in
// ST_SLOT one slot per cycle, and ends in ST_POP once the queue is empty.
// Visited vertices come out in visit order, each one held back until the next
// vertex leaves the queue or the queue runs empty; out_last marks the final
// result of an item. The user must write the vertex_count register over the
// APB-style port only while the block is idle; the block does not enforce it.

module graph_breadth_first_search #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_SLOTS    = 512
) (
  input  logic        clk,
  input  logic        rst_n,

  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [5:0]  in_first_vertex,
  input  logic [5:0]  in_second_vertex,

  // result channel
  output logic        out_valid,
  output logic [5:0]  out_vertex,
  output logic [1:0]  out_status,
  output logic        out_last,

  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // widths derived from the store sizes
  localparam int SW  = $clog2(MAX_SLOTS);        // slot index
  localparam int UW  = $clog2(MAX_SLOTS + 1);    // slot fill count
  localparam int VIW = $clog2(MAX_VERTICES);     // vertex index into stores
  localparam int QW  = $clog2(MAX_VERTICES + 1); // queue pointers
  localparam logic [6:0]  MAXV7     = 7'(MAX_VERTICES);
  localparam logic [UW:0] SLOTS_MAX = (UW + 1)'(MAX_SLOTS);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_ADD_RD_A = 9'b000000010,
    ST_ADD_WR_A = 9'b000000100,
    ST_ADD_RD_B = 9'b000001000,
    ST_ADD_WR_B = 9'b000010000,
    ST_POP      = 9'b000100000,
    ST_VTX      = 9'b001000000,
    ST_HEAD     = 9'b010000000,
    ST_SLOT     = 9'b100000000
  } state_t;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic [6:0]              vcount_r;
  logic [5:0]              a_r, a_nxt;
  logic [5:0]              b_r, b_nxt;
  logic [UW-1:0]           used_r, used_nxt;        // slots handed out
  logic [MAX_VERTICES-1:0] nonempty_r, nonempty_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [QW-1:0]           qh_r, qh_nxt;
  logic [QW-1:0]           qt_r, qt_nxt;
  logic [SW-1:0]           tail_r, tail_nxt;        // tail of list being walked
  logic [SW-1:0]           s_r, s_nxt;              // slot whose data is on the read port
  logic [5:0]              pend_r, pend_nxt;        // visited vertex held back for last flag
  logic                    pend_vld_r, pend_vld_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [5:0]              out_vertex_r, out_vertex_nxt;
  logic [1:0]              out_status_r, out_status_nxt;
  logic                    out_last_r, out_last_nxt;

  // ---------------------------------------------------------------------
  // Memories: list heads/tails, slot neighbor, slot next, vertex queue.
  // All one write port, one registered read port.
  // ---------------------------------------------------------------------
  logic [2*SW-1:0] list_mem [MAX_VERTICES];
  logic [5:0]      nb_mem   [MAX_SLOTS];
  logic [SW-1:0]   nx_mem   [MAX_SLOTS];
  logic [5:0]      q_mem    [MAX_VERTICES];

  logic            list_we;
  logic [VIW-1:0]  list_waddr, list_raddr;
  logic [2*SW-1:0] list_wdata, list_rdata;

  logic            nb_we;
  logic [SW-1:0]   nb_waddr;
  logic [5:0]      nb_wdata, nb_rdata;

  logic            nx_we;
  logic [SW-1:0]   nx_waddr;
  logic [SW-1:0]   nx_wdata, nx_rdata;

  logic [SW-1:0]   slot_raddr;

  logic            q_we;
  logic [VIW-1:0]  q_waddr, q_raddr;
  logic [5:0]      q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rdata <= list_mem[list_raddr];
  end

  always_ff @(posedge clk) begin
    if (nb_we) begin
      nb_mem[nb_waddr] <= nb_wdata;
    end
    nb_rdata <= nb_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      nx_mem[nx_waddr] <= nx_wdata;
    end
    nx_rdata <= nx_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rdata <= q_mem[q_raddr];
  end

  // ---------------------------------------------------------------------
  // Configuration port: single register, no wait states
  // ---------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == gbfs_pkg::REG_VERTEX_COUNT) ? {25'd0, vcount_r} : 32'd0;

  // effective vertex limit: min(vertex_count, MAX_VERTICES)
  logic [6:0] lim;
  assign lim = (vcount_r < MAXV7) ? vcount_r : MAXV7;

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  logic           accept;
  logic           wr_a;        // first append of an add (owner a, neighbor b)
  logic [5:0]     owner, nbv;
  logic [SW-1:0]  head_rd, tail_rd;
  logic [5:0]     u, w;
  logic           enq;

  assign accept  = start && (state_r == ST_IDLE);
  assign wr_a    = (state_r == ST_ADD_WR_A);
  assign owner   = wr_a ? a_r : b_r;
  assign nbv     = wr_a ? b_r : a_r;
  assign head_rd = list_rdata[2*SW-1:SW];
  assign tail_rd = list_rdata[SW-1:0];
  assign u       = q_rdata;
  assign w       = nb_rdata;
  assign enq     = ({1'b0, w} < lim) && !visited_r[w[VIW-1:0]] &&
                   (qt_r < QW'(MAX_VERTICES));

  always_comb begin
    state_nxt      = state_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    used_nxt       = used_r;
    nonempty_nxt   = nonempty_r;
    visited_nxt    = visited_r;
    qh_nxt         = qh_r;
    qt_nxt         = qt_r;
    tail_nxt       = tail_r;
    s_nxt          = s_r;
    pend_nxt       = pend_r;
    pend_vld_nxt   = pend_vld_r;
    out_valid_nxt  = 1'b0;
    out_vertex_nxt = 6'd0;
    out_status_nxt = gbfs_pkg::STS_OK;
    out_last_nxt   = 1'b1;

    list_we    = 1'b0;
    list_waddr = owner[VIW-1:0];
    list_wdata = {(nonempty_r[owner[VIW-1:0]] ? head_rd : used_r[SW-1:0]), used_r[SW-1:0]};
    list_raddr = a_r[VIW-1:0];
    nb_we      = 1'b0;
    nb_waddr   = used_r[SW-1:0];
    nb_wdata   = nbv;
    nx_we      = 1'b0;
    nx_waddr   = tail_rd;
    nx_wdata   = used_r[SW-1:0];
    slot_raddr = s_r;
    q_we       = 1'b0;
    q_waddr    = qt_r[VIW-1:0];
    q_wdata    = w;
    q_raddr    = qh_r[VIW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          a_nxt = in_first_vertex;
          b_nxt = in_second_vertex;
          case (in_operation)
            gbfs_pkg::OP_ADD: begin
              if (({1'b0, in_first_vertex} >= lim) || ({1'b0, in_second_vertex} >= lim)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = gbfs_pkg::STS_RANGE;
              end else if ((UW + 1)'(used_r) + (UW + 1)'(2) > SLOTS_MAX) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = gbfs_pkg::STS_FULL;
              end else begin
                state_nxt = ST_ADD_RD_A;
              end
            end
            gbfs_pkg::OP_SEARCH: begin
              if ({1'b0, in_first_vertex} >= lim) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = gbfs_pkg::STS_RANGE;
              end else begin
                // visited map cleared at once, source marked and queued
                visited_nxt = '0;
                visited_nxt[in_first_vertex[VIW-1:0]] = 1'b1;
                q_we         = 1'b1;
                q_waddr      = '0;
                q_wdata      = in_first_vertex;
                qh_nxt       = '0;
                qt_nxt       = QW'(1);
                pend_vld_nxt = 1'b0;
                state_nxt    = ST_POP;
              end
            end
            gbfs_pkg::OP_CLEAR: begin
              used_nxt      = '0;
              nonempty_nxt  = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ST_ADD_RD_A: begin
        list_raddr = a_r[VIW-1:0];
        state_nxt  = ST_ADD_WR_A;
      end

      ST_ADD_RD_B: begin
        list_raddr = b_r[VIW-1:0];
        state_nxt  = ST_ADD_WR_B;
      end

      ST_ADD_WR_A, ST_ADD_WR_B: begin
        // append: new slot, link from old tail, update head/tail
        nb_we   = 1'b1;
        nx_we   = nonempty_r[owner[VIW-1:0]];
        list_we = 1'b1;
        nonempty_nxt[owner[VIW-1:0]] = 1'b1;
        used_nxt = used_r + UW'(1);
        if (wr_a) begin
          state_nxt = ST_ADD_RD_B;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_POP: begin
        if (qh_r == qt_r) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = pend_r;
          out_status_nxt = gbfs_pkg::STS_VISIT;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          q_raddr   = qh_r[VIW-1:0];
          qh_nxt    = qh_r + QW'(1);
          state_nxt = ST_VTX;
        end
      end

      ST_VTX: begin
        if (pend_vld_r) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = pend_r;
          out_status_nxt = gbfs_pkg::STS_VISIT;
          out_last_nxt   = 1'b0;
        end
        pend_nxt     = u;
        pend_vld_nxt = 1'b1;
        list_raddr   = u[VIW-1:0];
        state_nxt    = nonempty_r[u[VIW-1:0]] ? ST_HEAD : ST_POP;
      end

      ST_HEAD: begin
        tail_nxt   = tail_rd;
        slot_raddr = head_rd;
        s_nxt      = head_rd;
        state_nxt  = ST_SLOT;
      end

      ST_SLOT: begin
        if (enq) begin
          visited_nxt[w[VIW-1:0]] = 1'b1;
          q_we   = 1'b1;
          qt_nxt = qt_r + QW'(1);
        end
        if (s_r == tail_r) begin
          state_nxt = ST_POP;
        end else begin
          slot_raddr = nx_rdata;
          s_nxt      = nx_rdata;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= gbfs_pkg::VERTEX_COUNT_RST;
      used_r      <= '0;
      nonempty_r  <= '0;
      visited_r   <= '0;
      qh_r        <= '0;
      qt_r        <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      nonempty_r  <= nonempty_nxt;
      visited_r   <= visited_nxt;
      qh_r        <= qh_nxt;
      qt_r        <= qt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && (paddr == gbfs_pkg::REG_VERTEX_COUNT)) begin
        vcount_r <= pwdata[6:0];
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    tail_r       <= tail_nxt;
    s_r          <= s_nxt;
    pend_r       <= pend_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_vertex = out_vertex_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// ===== bench/graph_breadth_first_search_tb.sv =====
`timescale 1ns / 100ps
// graph_breadth_first_search_tb: self-checking bench for the adjacency-list BFS block.
// Depends on gbfs_pkg and graph_breadth_first_search; drives commands and APB writes,
// predicts every result in-bench and checks each transfer in order.
module graph_breadth_first_search_tb;

  localparam int VERTEX_TOTAL = 64;
  localparam int SLOT_TOTAL   = 512;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int WANT_DEPTH   = 256;
  localparam int PLAN_DEPTH   = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;  // block ignores it, no result

  typedef struct packed {
    logic [5:0]        vertex;
    gbfs_pkg::status_t status;
    logic              last;
  } result_t;

  // one line of the directed plan: either a register write or a command
  typedef struct {
    bit                is_cfg;
    logic [6:0]        cfg_value;
    logic [1:0]        op;
    logic [5:0]        a;
    logic [5:0]        b;
    bit                typed;
    gbfs_pkg::status_t t_status;
    logic [5:0]        t_vertex;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [5:0]  in_first_vertex;
  logic [5:0]  in_second_vertex;
  logic        out_valid;
  logic [5:0]  out_vertex;
  logic [1:0]  out_status;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  graph_breadth_first_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_first_vertex  (in_first_vertex),
    .in_second_vertex (in_second_vertex),
    .out_valid        (out_valid),
    .out_vertex       (out_vertex),
    .out_status       (out_status),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Graph shadow: neighbor lists in a shared slot pool, plus BFS scratch.
  // Only entries that were written are ever read, same as the block.
  // ---------------------------------------------------------------------------
  logic [6:0]  vcount;
  logic [9:0]  adj_head [VERTEX_TOTAL];
  logic [9:0]  adj_tail [VERTEX_TOTAL];
  bit          adj_used [VERTEX_TOTAL];
  logic [5:0]  nbr_id   [SLOT_TOTAL];
  logic [9:0]  nbr_link [SLOT_TOTAL];
  int unsigned slot_count;
  bit          seen     [VERTEX_TOTAL];
  logic [5:0]  bfs_queue[VERTEX_TOTAL];

  // expected transfers, oldest at want_rd
  result_t     want_q [WANT_DEPTH];
  int unsigned want_wr;
  int unsigned want_rd;

  // results of the latest prediction
  result_t     pred_res [VERTEX_TOTAL];
  int unsigned pred_n;

  plan_row_t   plan [PLAN_DEPTH];
  int unsigned plan_n;

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned searches_run;
  int unsigned full_rejects;
  int unsigned range_rejects;
  int unsigned cycles;
  bit          idling_on;

  function automatic int unsigned active_limit();
    return (vcount < VERTEX_TOTAL) ? 32'(vcount) : 32'(VERTEX_TOTAL);
  endfunction

  function automatic int unsigned want_count();
    return want_wr - want_rd;
  endfunction

  function automatic void want_add(input result_t r);
    want_q[want_wr % WANT_DEPTH] = r;
    want_wr++;
  endfunction

  function automatic void pred_add(input result_t r);
    pred_res[pred_n] = r;
    pred_n++;
  endfunction

  // append nb to the tail of owner's list
  function automatic void link_slot(input logic [5:0] owner, input logic [5:0] nb);
    logic [9:0] s;
    s = 10'(slot_count);
    nbr_id[s]   = nb;
    nbr_link[s] = '0;
    if (adj_used[owner]) nbr_link[adj_tail[owner]] = s;
    else begin
      adj_head[owner] = s;
      adj_used[owner] = 1'b1;
    end
    adj_tail[owner] = s;
    slot_count++;
  endfunction

  function automatic result_t mk_result(input logic [5:0] v, input gbfs_pkg::status_t st,
                                        input logic lst);
    result_t r;
    r.vertex = v;
    r.status = st;
    r.last   = lst;
    return r;
  endfunction

  // Works out the results of one command and advances the shadow graph.
  function automatic void predict_graph_op(input logic [1:0] op, input logic [5:0] a,
                                           input logic [5:0] b);
    int unsigned lim;
    int unsigned qh;
    int unsigned qt;
    int unsigned steps;
    logic [5:0]  u;
    logic [5:0]  w;
    logic [9:0]  s;
    lim = active_limit();
    pred_n = 0;
    case (op)
      gbfs_pkg::OP_ADD: begin
        if (a >= lim || b >= lim) pred_add(mk_result('0, gbfs_pkg::STS_RANGE, 1'b1));
        else if (slot_count + 2 > SLOT_TOTAL)
          pred_add(mk_result('0, gbfs_pkg::STS_FULL, 1'b1));
        else begin
          // self loop lands twice in its own list
          link_slot(a, b);
          link_slot(b, a);
          pred_add(mk_result('0, gbfs_pkg::STS_OK, 1'b1));
        end
      end
      gbfs_pkg::OP_SEARCH: begin
        if (a >= lim) pred_add(mk_result('0, gbfs_pkg::STS_RANGE, 1'b1));
        else begin
          foreach (seen[i]) seen[i] = 1'b0;
          seen[a] = 1'b1;
          bfs_queue[0] = a;
          qh = 0;
          qt = 1;
          while (qh < qt) begin
            u = bfs_queue[qh];
            qh++;
            pred_add(mk_result(u, gbfs_pkg::STS_VISIT, 1'b0));
            if (adj_used[u]) begin
              s = adj_head[u];
              for (steps = 0; steps < SLOT_TOTAL; steps++) begin
                if (s >= SLOT_TOTAL) break;
                w = nbr_id[s];
                // neighbors at or above a lowered limit are skipped
                if (w < lim && !seen[w] && qt < VERTEX_TOTAL) begin
                  seen[w] = 1'b1;
                  bfs_queue[qt] = w;
                  qt++;
                end
                if (s == adj_tail[u]) break;
                s = nbr_link[s];
              end
            end
          end
          pred_res[pred_n - 1].last = 1'b1;
        end
      end
      gbfs_pkg::OP_CLEAR: begin
        foreach (adj_used[i]) adj_used[i] = 1'b0;
        slot_count = 0;
        pred_add(mk_result('0, gbfs_pkg::STS_OK, 1'b1));
      end
      default: ;  // unused opcode: nothing happens
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor: the block never waits, so every out_valid cycle is a
  // transfer, compared field by field with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (want_count() == 0) begin
        report_mismatch($sformatf("unexpected result vertex %0d status %0d last %0b",
                                  out_vertex, out_status, out_last));
      end else begin
        e = want_q[want_rd % WANT_DEPTH];
        want_rd++;
        if (out_vertex !== e.vertex)
          report_mismatch($sformatf("vertex %0d, want %0d", out_vertex, e.vertex));
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, e.status));
        if (out_last !== e.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, e.last));
      end
    end
  end

  // global watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               want_count());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Present a command at the falling edge and hold it until a rising edge with
  // busy low takes it. start is left high; the next call replaces it or a pause lowers it.
  task automatic send_cmd(input logic [1:0] op, input logic [5:0] a, input logic [5:0] b,
                          input bit typed, input gbfs_pkg::status_t t_st,
                          input logic [5:0] t_v);
    @(negedge clk);
    start            <= 1'b1;
    in_operation     <= op;
    in_first_vertex  <= a;
    in_second_vertex <= b;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_graph_op(op, a, b);
    // directed rows with a typed answer still advance the shadow graph
    if (typed) begin
      want_add(mk_result(t_v, t_st, 1'b1));
    end else begin
      for (int unsigned i = 0; i < pred_n; i++) want_add(pred_res[i]);
    end
    if (op != OP_UNUSED) items_sent++;
    if (op == gbfs_pkg::OP_SEARCH && pred_n > 0 && pred_res[0].status == gbfs_pkg::STS_VISIT)
      searches_run++;
    if (pred_n > 0 && pred_res[0].status == gbfs_pkg::STS_FULL) full_rejects++;
    if (pred_n > 0 && pred_res[0].status == gbfs_pkg::STS_RANGE) range_rejects++;
  endtask

  task automatic pause_sender(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // random gap burst, only while idling is enabled
  task automatic maybe_gap();
    if (idling_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 17));
  endtask

  // Sender holds off until every expected transfer has come, then allows for
  // a trailing ignored command still in flight before going quiet.
  task automatic drain_results();
    pause_sender(1);
    while (want_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // APB write of vertex_count, then a read back; only called with the block idle
  task automatic write_vertex_count(input logic [6:0] v);
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= gbfs_pkg::REG_VERTEX_COUNT;
    pwdata  <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    vcount = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata[6:0] !== v)
      report_mismatch($sformatf("vertex_count reads %0d, wrote %0d", prdata[6:0], v));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly ids inside the active limit, some anywhere in the 6-bit field
  function automatic logic [5:0] pick_vertex();
    int unsigned l;
    l = active_limit();
    if (l > 0 && $urandom_range(0, 4) != 0) return 6'($urandom_range(0, l - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  // one random command; returns 1 when it counts as a real item
  task automatic random_cmd(input bit allow_clear, output bit counted);
    int unsigned r;
    logic [1:0]  op;
    logic [5:0]  a;
    logic [5:0]  b;
    r = $urandom_range(0, 99);
    if (r < 55) op = gbfs_pkg::OP_ADD;
    else if (r < 85) op = gbfs_pkg::OP_SEARCH;
    else if (r < 91 && allow_clear) op = gbfs_pkg::OP_CLEAR;
    else if (r < 91) op = gbfs_pkg::OP_SEARCH;
    else op = OP_UNUSED;
    a = pick_vertex();
    b = ($urandom_range(0, 9) == 0) ? a : pick_vertex();  // some self loops
    if (op == OP_UNUSED || op == gbfs_pkg::OP_CLEAR) b = 6'($urandom_range(0, 63));
    send_cmd(op, a, b, 1'b0, gbfs_pkg::STS_VISIT, '0);
    counted = (op != OP_UNUSED);
    maybe_gap();
  endtask

  // directed plan builders
  function automatic plan_row_t blank_row();
    plan_row_t p;
    p.is_cfg    = 1'b0;
    p.cfg_value = '0;
    p.op        = '0;
    p.a         = '0;
    p.b         = '0;
    p.typed     = 1'b0;
    p.t_status  = gbfs_pkg::STS_VISIT;
    p.t_vertex  = '0;
    return p;
  endfunction

  function automatic void plan_add(input plan_row_t p);
    plan[plan_n] = p;
    plan_n++;
  endfunction

  function automatic void cmd_row(input logic [1:0] op, input logic [5:0] a,
                                  input logic [5:0] b);
    plan_row_t p;
    p = blank_row();
    p.op = op;
    p.a  = a;
    p.b  = b;
    plan_add(p);
  endfunction

  function automatic void typed_row(input logic [1:0] op, input logic [5:0] a,
                                    input logic [5:0] b, input gbfs_pkg::status_t st,
                                    input logic [5:0] v);
    plan_row_t p;
    p = blank_row();
    p.op       = op;
    p.a        = a;
    p.b        = b;
    p.typed    = 1'b1;
    p.t_status = st;
    p.t_vertex = v;
    plan_add(p);
  endfunction

  function automatic void cfg_row(input logic [6:0] v);
    plan_row_t p;
    p = blank_row();
    p.is_cfg    = 1'b1;
    p.cfg_value = v;
    plan_add(p);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [6:0] seg_cfg[6];
    bit         counted;
    int unsigned n;
    int unsigned k;

    // every input known from time zero
    rst_n            = 1'b0;
    start            = 1'b0;
    in_operation     = '0;
    in_first_vertex  = '0;
    in_second_vertex = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    mismatches       = 0;
    items_sent       = 0;
    results_seen     = 0;
    searches_run     = 0;
    full_rejects     = 0;
    range_rejects    = 0;
    cycles           = 0;
    idling_on        = 1'b0;
    want_wr          = 0;
    want_rd          = 0;
    pred_n           = 0;
    plan_n           = 0;

    vcount     = gbfs_pkg::VERTEX_COUNT_RST;
    slot_count = 0;
    foreach (adj_used[i]) adj_used[i] = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed plan -------------------------------------------------------
    // empty graph: source only
    typed_row(gbfs_pkg::OP_SEARCH, 6'd0, 6'd0, gbfs_pkg::STS_VISIT, 6'd0);
    typed_row(gbfs_pkg::OP_ADD, 6'd0, 6'd63, gbfs_pkg::STS_OK, 6'd0);
    typed_row(gbfs_pkg::OP_ADD, 6'd63, 6'd63, gbfs_pkg::STS_OK, 6'd0);  // self loop
    typed_row(gbfs_pkg::OP_ADD, 6'd0, 6'd1, gbfs_pkg::STS_OK, 6'd0);
    cmd_row(gbfs_pkg::OP_ADD, 6'd1, 6'd2);
    cmd_row(gbfs_pkg::OP_ADD, 6'd2, 6'd63);
    cmd_row(gbfs_pkg::OP_ADD, 6'd5, 6'd6);
    cmd_row(gbfs_pkg::OP_SEARCH, 6'd0, 6'd0);
    cmd_row(gbfs_pkg::OP_SEARCH, 6'd63, 6'd21);
    cmd_row(gbfs_pkg::OP_SEARCH, 6'd5, 6'd63);
    cmd_row(OP_UNUSED, 6'd63, 6'd63);                    // ignored opcode
    cfg_row(7'd3);                                       // lowered: 63 now skipped
    cmd_row(gbfs_pkg::OP_SEARCH, 6'd0, 6'd0);
    typed_row(gbfs_pkg::OP_ADD, 6'd0, 6'd63, gbfs_pkg::STS_RANGE, 6'd0);
    typed_row(gbfs_pkg::OP_SEARCH, 6'd63, 6'd0, gbfs_pkg::STS_RANGE, 6'd0);
    typed_row(gbfs_pkg::OP_ADD, 6'd3, 6'd0, gbfs_pkg::STS_RANGE, 6'd0);
    cfg_row(7'd0);                                       // nothing in range
    typed_row(gbfs_pkg::OP_SEARCH, 6'd0, 6'd0, gbfs_pkg::STS_RANGE, 6'd0);
    typed_row(gbfs_pkg::OP_ADD, 6'd0, 6'd0, gbfs_pkg::STS_RANGE, 6'd0);
    cfg_row(7'd127);                                     // above the array size
    cmd_row(gbfs_pkg::OP_SEARCH, 6'd63, 6'd0);
    typed_row(gbfs_pkg::OP_CLEAR, 6'd42, 6'd21, gbfs_pkg::STS_OK, 6'd0);
    typed_row(gbfs_pkg::OP_SEARCH, 6'd63, 6'd0, gbfs_pkg::STS_VISIT, 6'd63);
    cfg_row(7'd64);
    cmd_row(OP_UNUSED, 6'd0, 6'd0);

    for (int unsigned i = 0; i < plan_n; i++) begin
      if (plan[i].is_cfg) write_vertex_count(plan[i].cfg_value);
      else send_cmd(plan[i].op, plan[i].a, plan[i].b, plan[i].typed,
                    plan[i].t_status, plan[i].t_vertex);
    end

    // --- mixed random segments, one count setting each ------------------------
    seg_cfg = '{7'd1, 7'd127, 7'd0, 7'd13, 7'd2, 7'd64};
    foreach (seg_cfg[s]) begin
      write_vertex_count(seg_cfg[s]);
      idling_on = s[0];   // alternate gappy and back-to-back stretches
      n = 0;
      while (n < 22) begin
        random_cmd(1'b1, counted);
        if (counted) n++;
      end
    end

    // --- fill the slot pool until edges get dropped ---------------------------
    write_vertex_count(7'd64);
    idling_on = 1'b1;
    send_cmd(gbfs_pkg::OP_CLEAR, 6'd0, 6'd0, 1'b0, gbfs_pkg::STS_VISIT, '0);
    k = 0;
    while (slot_count + 2 <= SLOT_TOTAL) begin
      k++;
      if (k % 16 == 0)
        send_cmd(gbfs_pkg::OP_SEARCH, pick_vertex(), 6'd0, 1'b0, gbfs_pkg::STS_VISIT, '0);
      else
        send_cmd(gbfs_pkg::OP_ADD, pick_vertex(), pick_vertex(), 1'b0,
                 gbfs_pkg::STS_VISIT, '0);
      maybe_gap();
    end
    repeat (6) begin
      send_cmd(gbfs_pkg::OP_ADD, pick_vertex(), pick_vertex(), 1'b0,
               gbfs_pkg::STS_VISIT, '0);
      maybe_gap();
    end
    send_cmd(gbfs_pkg::OP_SEARCH, pick_vertex(), 6'd0, 1'b0, gbfs_pkg::STS_VISIT, '0);

    // sender holds off until the dense search has fully come out
    drain_results();

    // lower the count over a full graph without clearing it
    write_vertex_count(7'd40);
    n = 0;
    while (n < 12) begin
      random_cmd(1'b0, counted);
      if (counted) n++;
    end

    // --- closing stretch, no gaps ---------------------------------------------
    idling_on = 1'b0;
    send_cmd(gbfs_pkg::OP_CLEAR, 6'd0, 6'd0, 1'b0, gbfs_pkg::STS_VISIT, '0);
    n = 0;
    while (n < 35) begin
      random_cmd(1'b1, counted);
      if (counted) n++;
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (want_count() != 0)
      report_mismatch($sformatf("%0d results never arrived", want_count()));

    $display("run: %0d commands, %0d searches walked, %0d results checked",
             items_sent, searches_run, results_seen);
    $display("     %0d store-full and %0d out-of-range rejects, %0d mismatches",
             full_rejects, range_rejects, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
